@@ design/ujs_pkg.sv @@
`default_nettype none
package ujs_pkg;

  localparam int MAX_BYTES = 6;
  localparam int POS_W     = $clog2(MAX_BYTES);
  localparam int NB_W      = $clog2(MAX_BYTES + 1);
  localparam int LIMIT_W   = 19;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 19'h40000;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6e;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_U = 8'h75;
  localparam logic [7:0] CH_ZERO = 8'h30;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_UNIT  = 2'd1,
    MODE_END   = 2'd2,
    MODE_RSVD  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ERR_NONE          = 2'd0,
    ERR_LONE_LOW      = 2'd1,
    ERR_UNPAIRED_HIGH = 2'd2,
    ERR_OVER_LIMIT    = 2'd3
  } err_t;

  // one classified item: the bytes it produces, in order
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [NB_W-1:0]           nbytes;
    err_t                      err;
  } job_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'd0, v};
    end else begin
      r = 8'h57 + {4'd0, v};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/ujs_in_if.sv @@
`default_nettype none
interface ujs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] code_unit;

  modport source (output valid, output mode, output code_unit, input ready);
  modport sink (input valid, input mode, input code_unit, output ready);
endinterface
`default_nettype wire

@@ design/ujs_out_if.sv @@
`default_nettype none
interface ujs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic [1:0] error_code;

  modport source (output valid, output out_byte, output run_last, output error_code,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input error_code,
                output ready);
endinterface
`default_nettype wire

@@ design/ujs_cfg_if.sv @@
`default_nettype none
interface ujs_cfg_if;
  logic        valid;
  logic        ready;
  logic [18:0] utf8_byte_limit;

  modport source (output valid, output utf8_byte_limit, input ready);
  modport sink (input valid, input utf8_byte_limit, output ready);
endinterface
`default_nettype wire

@@ design/utf16_to_json_utf8_escaper_top.sv @@
// Converts framed UTF-16 code units into a quoted, escaped JSON string in UTF-8,
// one byte per output transfer, run_last marking the final byte of each input
// item. An input transfer is taken every cycle while the four-entry job queue
// between the classifier and the byte serialiser has room; the serialiser drives
// one byte per cycle unless the output stalls; an item produces 0 to 6 bytes (4
// for a surrogate pair, 6 for a backslash-u escape) and the queue absorbs short
// bursts. Errors (lone low surrogate, unpaired high surrogate, length over
// utf8_byte_limit) give one zero byte with the error code, after which the string
// is dropped until the next start. The limit register is written through the
// always-ready cfg channel by the user only while idle; the block does not check.
`default_nettype none
module utf16_to_json_utf8_escaper_top (
  input  wire        clk,
  input  wire        rst_n,
  ujs_in_if.sink     in_ch,
  ujs_out_if.source  out_ch,
  ujs_cfg_if.sink    cfg_ch
);

  ujs_pkg::job_t push_data, pop_data;
  logic          push, pop, full, empty;

  ujs_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (full),
    .q_push (push),
    .q_data (push_data)
  );

  ujs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  ujs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_data  (pop_data),
    .q_empty (empty),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

@@ design/ujs_front.sv @@
`default_nettype none
module ujs_front (
  input  wire            clk,
  input  wire            rst_n,
  ujs_in_if.sink         in_ch,
  ujs_cfg_if.sink        cfg_ch,
  input  wire            q_full,
  output logic           q_push,
  output ujs_pkg::job_t  q_data
);

  logic [ujs_pkg::LIMIT_W-1:0] limit_r;
  logic [9:0]                  high_half_r, high_half_nxt;
  logic                        pending_r, pending_nxt;
  logic [ujs_pkg::LIMIT_W-1:0] count_r, count_nxt;
  logic                        failed_r, failed_nxt;

  ujs_pkg::mode_t  mode;
  logic [15:0]     c;
  logic            accept;
  logic            is_low, is_high;
  logic [2:0]      add;
  logic [ujs_pkg::LIMIT_W:0] total;
  logic [20:0]     cp;
  ujs_pkg::job_t   job;
  logic            has_job;

  assign mode   = ujs_pkg::mode_t'(in_ch.mode);
  assign c      = in_ch.code_unit;
  assign accept = in_ch.valid && in_ch.ready;

  assign in_ch.ready  = !q_full;
  assign cfg_ch.ready = 1'b1;

  assign is_low  = (c[15:10] == 6'b110111);
  assign is_high = (c[15:10] == 6'b110110);
  assign cp      = {1'b0, high_half_r, c[9:0]} + 21'h10000;

  always_comb begin
    if (pending_r) begin
      add = 3'd4;
    end else if (c < 16'h0080) begin
      add = 3'd1;
    end else if (c < 16'h0800) begin
      add = 3'd2;
    end else begin
      add = 3'd3;
    end
  end

  assign total = {1'b0, count_r} + {{(ujs_pkg::LIMIT_W-2){1'b0}}, add};

  always_comb begin
    high_half_nxt = high_half_r;
    pending_nxt   = pending_r;
    count_nxt     = count_r;
    failed_nxt    = failed_r;
    job           = '0;
    job.err       = ujs_pkg::ERR_NONE;
    has_job       = 1'b0;

    case (mode)
      ujs_pkg::MODE_START: begin
        high_half_nxt = '0;
        pending_nxt   = 1'b0;
        count_nxt     = '0;
        failed_nxt    = 1'b0;
        job.bytes[0]  = ujs_pkg::CH_QUOTE;
        job.nbytes    = ujs_pkg::NB_W'(1);
        has_job       = 1'b1;
      end
      ujs_pkg::MODE_UNIT: begin
        if (!failed_r) begin
          if (pending_r && !is_low) begin
            job.nbytes  = ujs_pkg::NB_W'(1);
            job.err     = ujs_pkg::ERR_UNPAIRED_HIGH;
            has_job     = 1'b1;
            failed_nxt  = 1'b1;
            pending_nxt = 1'b0;
          end else if (!pending_r && is_low) begin
            job.nbytes  = ujs_pkg::NB_W'(1);
            job.err     = ujs_pkg::ERR_LONE_LOW;
            has_job     = 1'b1;
            failed_nxt  = 1'b1;
          end else if (!pending_r && is_high) begin
            high_half_nxt = c[9:0];
            pending_nxt   = 1'b1;
          end else if (total > {1'b0, limit_r}) begin
            job.nbytes  = ujs_pkg::NB_W'(1);
            job.err     = ujs_pkg::ERR_OVER_LIMIT;
            has_job     = 1'b1;
            failed_nxt  = 1'b1;
            pending_nxt = 1'b0;
          end else begin
            count_nxt = total[ujs_pkg::LIMIT_W-1:0];
            has_job   = 1'b1;
            if (pending_r) begin
              pending_nxt  = 1'b0;
              job.bytes[0] = {5'b11110, cp[20:18]};
              job.bytes[1] = {2'b10, cp[17:12]};
              job.bytes[2] = {2'b10, cp[11:6]};
              job.bytes[3] = {2'b10, cp[5:0]};
              job.nbytes   = ujs_pkg::NB_W'(4);
            end else begin
              case (c)
                16'h0022: begin
                  job.bytes[0] = ujs_pkg::CH_BSLASH;
                  job.bytes[1] = ujs_pkg::CH_QUOTE;
                  job.nbytes   = ujs_pkg::NB_W'(2);
                end
                16'h005c: begin
                  job.bytes[0] = ujs_pkg::CH_BSLASH;
                  job.bytes[1] = ujs_pkg::CH_BSLASH;
                  job.nbytes   = ujs_pkg::NB_W'(2);
                end
                16'h0008: begin
                  job.bytes[0] = ujs_pkg::CH_BSLASH;
                  job.bytes[1] = ujs_pkg::CH_B;
                  job.nbytes   = ujs_pkg::NB_W'(2);
                end
                16'h000c: begin
                  job.bytes[0] = ujs_pkg::CH_BSLASH;
                  job.bytes[1] = ujs_pkg::CH_F;
                  job.nbytes   = ujs_pkg::NB_W'(2);
                end
                16'h000a: begin
                  job.bytes[0] = ujs_pkg::CH_BSLASH;
                  job.bytes[1] = ujs_pkg::CH_N;
                  job.nbytes   = ujs_pkg::NB_W'(2);
                end
                16'h000d: begin
                  job.bytes[0] = ujs_pkg::CH_BSLASH;
                  job.bytes[1] = ujs_pkg::CH_R;
                  job.nbytes   = ujs_pkg::NB_W'(2);
                end
                16'h0009: begin
                  job.bytes[0] = ujs_pkg::CH_BSLASH;
                  job.bytes[1] = ujs_pkg::CH_T;
                  job.nbytes   = ujs_pkg::NB_W'(2);
                end
                default: begin
                  if (c < 16'h0020) begin
                    job.bytes[0] = ujs_pkg::CH_BSLASH;
                    job.bytes[1] = ujs_pkg::CH_U;
                    job.bytes[2] = ujs_pkg::CH_ZERO;
                    job.bytes[3] = ujs_pkg::CH_ZERO;
                    job.bytes[4] = ujs_pkg::hex_digit(c[7:4]);
                    job.bytes[5] = ujs_pkg::hex_digit(c[3:0]);
                    job.nbytes   = ujs_pkg::NB_W'(6);
                  end else if (c < 16'h0080) begin
                    job.bytes[0] = c[7:0];
                    job.nbytes   = ujs_pkg::NB_W'(1);
                  end else if (c < 16'h0800) begin
                    job.bytes[0] = {3'b110, c[10:6]};
                    job.bytes[1] = {2'b10, c[5:0]};
                    job.nbytes   = ujs_pkg::NB_W'(2);
                  end else begin
                    job.bytes[0] = {4'b1110, c[15:12]};
                    job.bytes[1] = {2'b10, c[11:6]};
                    job.bytes[2] = {2'b10, c[5:0]};
                    job.nbytes   = ujs_pkg::NB_W'(3);
                  end
                end
              endcase
            end
          end
        end
      end
      ujs_pkg::MODE_END: begin
        if (!failed_r) begin
          if (pending_r) begin
            job.nbytes  = ujs_pkg::NB_W'(1);
            job.err     = ujs_pkg::ERR_UNPAIRED_HIGH;
            has_job     = 1'b1;
            failed_nxt  = 1'b1;
            pending_nxt = 1'b0;
          end else begin
            count_nxt    = '0;
            job.bytes[0] = ujs_pkg::CH_QUOTE;
            job.nbytes   = ujs_pkg::NB_W'(1);
            has_job      = 1'b1;
          end
        end
      end
      default: begin
        // reserved mode: no output, state held
      end
    endcase
  end

  assign q_push = accept && has_job;
  assign q_data = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= ujs_pkg::LIMIT_RESET;
      high_half_r <= '0;
      pending_r   <= 1'b0;
      count_r     <= '0;
      failed_r    <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        limit_r <= cfg_ch.utf8_byte_limit;
      end
      if (accept) begin
        high_half_r <= high_half_nxt;
        pending_r   <= pending_nxt;
        count_r     <= count_nxt;
        failed_r    <= failed_nxt;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/ujs_fifo.sv @@
`default_nettype none
module ujs_fifo (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            push,
  input  ujs_pkg::job_t  push_data,
  input  wire            pop,
  output ujs_pkg::job_t  pop_data,
  output logic           full,
  output logic           empty
);

  ujs_pkg::job_t               mem_r [ujs_pkg::QDEPTH];
  logic [ujs_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [ujs_pkg::QCNT_W-1:0]  count_r;
  logic                        do_push, do_pop;

  assign full     = (count_r == ujs_pkg::QCNT_W'(ujs_pkg::QDEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  function automatic logic [ujs_pkg::QPTR_W-1:0] wrap_inc(
    input logic [ujs_pkg::QPTR_W-1:0] p);
    logic [ujs_pkg::QPTR_W-1:0] r;
    if (p == ujs_pkg::QPTR_W'(ujs_pkg::QDEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/ujs_back.sv @@
`default_nettype none
module ujs_back (
  input  wire            clk,
  input  wire            rst_n,
  input  ujs_pkg::job_t  q_data,
  input  wire            q_empty,
  output logic           q_pop,
  ujs_out_if.source      out_ch
);

  ujs_pkg::job_t              job_r;
  logic                       job_valid_r;
  logic [ujs_pkg::POS_W-1:0]  pos_r;
  logic                       out_valid_r;
  logic [7:0]                 out_byte_r;
  logic                       out_last_r;
  logic [1:0]                 out_err_r;

  logic emit, emit_last;

  assign emit      = job_valid_r && (!out_valid_r || out_ch.ready);
  assign emit_last = emit &&
                     (pos_r == ujs_pkg::POS_W'(job_r.nbytes - 1'b1));
  // refill the working slot as its last byte leaves
  assign q_pop     = !q_empty && (!job_valid_r || emit_last);

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.run_last   = out_last_r;
  assign out_ch.error_code = out_err_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_data;
    end
    if (emit) begin
      out_byte_r <= job_r.bytes[pos_r];
      out_last_r <= emit_last;
      out_err_r  <= job_r.err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        job_valid_r <= 1'b1;
        pos_r       <= '0;
      end else if (emit_last) begin
        job_valid_r <= 1'b0;
      end else if (emit) begin
        pos_r <= pos_r + 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ tb/utf16_to_json_utf8_escaper_top_tb.sv @@
`timescale 1ns / 1ps
module utf16_to_json_utf8_escaper_top_tb;
  import ujs_pkg::*;

  localparam int WD_LIMIT     = 2000;
  localparam int DRAIN_CYCLES = 24;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] cu;
  } unit_item_t;

  typedef struct packed {
    logic [7:0] ob;
    logic       last;
    err_t       err;
  } json_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ujs_in_if  in_ch();
  ujs_out_if out_ch();
  ujs_cfg_if cfg_ch();

  logic        in_valid = 1'b0;
  logic [1:0]  in_mode = MODE_START;
  logic [15:0] in_cu = 16'h0000;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [18:0] cfg_limit = LIMIT_RESET;

  assign in_ch.valid              = in_valid;
  assign in_ch.mode               = in_mode;
  assign in_ch.code_unit          = in_cu;
  assign out_ch.ready             = out_ready;
  assign cfg_ch.valid             = cfg_valid;
  assign cfg_ch.utf8_byte_limit   = cfg_limit;

  utf16_to_json_utf8_escaper_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // escaper state as the testbench tracks it
  logic [18:0] byte_limit = LIMIT_RESET;
  logic [9:0]  hi_half = '0;
  bit          hi_pend = 1'b0;
  logic [18:0] u8_count = '0;
  bit          str_failed = 1'b0;

  unit_item_t  unit_q[$];
  json_byte_t  json_q[$];

  int unsigned in_acc_cnt = 0;
  int unsigned in_seen_cnt = 0;
  bit          in_busy = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;
  bit          calm = 1'b0;
  int unsigned n_queued = 0;
  int unsigned n_bytes = 0;
  int unsigned n_limits = 0;
  int unsigned n_errors = 0;
  int unsigned wd_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report(input string msg);
    n_errors++;
    if (n_errors <= MAX_REPORTS) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  // works out the json bytes one accepted item gives and updates the state
  task automatic escape_item(input logic [1:0] m, input logic [15:0] cu);
    logic [7:0]  b [0:5];
    int          n;
    int          add;
    logic [19:0] sum;
    logic [20:0] cp;
    bit          err_hit;
    err_t        code;
    json_byte_t  jb;
    n = 0;
    add = 0;
    err_hit = 1'b0;
    code = ERR_NONE;
    case (m)
      MODE_START: begin
        hi_pend = 1'b0;
        hi_half = '0;
        u8_count = '0;
        str_failed = 1'b0;
        b[0] = CH_QUOTE;
        n = 1;
      end
      MODE_UNIT: begin
        if (!str_failed) begin
          if (hi_pend) begin
            if (cu < 16'hdc00 || cu > 16'hdfff) begin
              err_hit = 1'b1;
              code = ERR_UNPAIRED_HIGH;
            end else begin
              add = 4;
            end
          end else if (cu >= 16'hdc00 && cu <= 16'hdfff) begin
            err_hit = 1'b1;
            code = ERR_LONE_LOW;
          end else if (cu >= 16'hd800 && cu <= 16'hdbff) begin
            hi_half = cu[9:0];
            hi_pend = 1'b1;
          end else begin
            add = (cu < 16'h0080) ? 1 : ((cu < 16'h0800) ? 2 : 3);
          end
          if (add != 0) begin
            sum = {1'b0, u8_count} + add[19:0];
            if (sum > {1'b0, byte_limit}) begin
              err_hit = 1'b1;
              code = ERR_OVER_LIMIT;
            end else begin
              u8_count = sum[18:0];
              if (hi_pend) begin
                cp = 21'h10000 + {1'b0, hi_half, 10'd0} + {5'd0, cu - 16'hdc00};
                hi_pend = 1'b0;
                b[0] = 8'hf0 | {5'd0, cp[20:18]};
                b[1] = 8'h80 | {2'd0, cp[17:12]};
                b[2] = 8'h80 | {2'd0, cp[11:6]};
                b[3] = 8'h80 | {2'd0, cp[5:0]};
                n = 4;
              end else begin
                b[0] = CH_BSLASH;
                n = 2;
                case (cu)
                  16'h0022: b[1] = CH_QUOTE;
                  16'h005c: b[1] = CH_BSLASH;
                  16'h0008: b[1] = CH_B;
                  16'h000c: b[1] = CH_F;
                  16'h000a: b[1] = CH_N;
                  16'h000d: b[1] = CH_R;
                  16'h0009: b[1] = CH_T;
                  default: begin
                    if (cu < 16'h0020) begin
                      b[1] = CH_U;
                      b[2] = CH_ZERO;
                      b[3] = CH_ZERO;
                      b[4] = CH_ZERO + {4'd0, cu[7:4]};
                      b[5] = (cu[3:0] < 4'd10) ? CH_ZERO + {4'd0, cu[3:0]}
                                               : 8'h57 + {4'd0, cu[3:0]};
                      n = 6;
                    end else if (cu < 16'h0080) begin
                      b[0] = cu[7:0];
                      n = 1;
                    end else if (cu < 16'h0800) begin
                      b[0] = 8'hc0 | {3'd0, cu[10:6]};
                      b[1] = 8'h80 | {2'd0, cu[5:0]};
                      n = 2;
                    end else begin
                      b[0] = 8'he0 | {4'd0, cu[15:12]};
                      b[1] = 8'h80 | {2'd0, cu[11:6]};
                      b[2] = 8'h80 | {2'd0, cu[5:0]};
                      n = 3;
                    end
                  end
                endcase
              end
            end
          end
        end
      end
      MODE_END: begin
        if (!str_failed) begin
          if (hi_pend) begin
            err_hit = 1'b1;
            code = ERR_UNPAIRED_HIGH;
          end else begin
            u8_count = '0;
            b[0] = CH_QUOTE;
            n = 1;
          end
        end
      end
      default: ;
    endcase
    if (err_hit) begin
      str_failed = 1'b1;
      hi_pend = 1'b0;
      jb.ob = 8'h00;
      jb.last = 1'b1;
      jb.err = code;
      json_q.insert(json_q.size(), jb);
    end else begin
      for (int i = 0; i < n; i++) begin
        jb.ob = b[i];
        jb.last = (i == n - 1);
        jb.err = ERR_NONE;
        json_q.insert(json_q.size(), jb);
      end
    end
  endtask

  task automatic queue_unit(input logic [1:0] m, input logic [15:0] cu);
    unit_item_t it;
    it.mode = m;
    it.cu = cu;
    unit_q.insert(unit_q.size(), it);
    if (m != MODE_RSVD) begin
      n_queued++;
    end
  endtask

  task automatic write_limit(input logic [18:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_limit <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    byte_limit = v;
    n_limits++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // held high surrogates and dropped strings give nothing, so wait a little longer
  task automatic drain();
    while (unit_q.size() != 0 || in_valid || json_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic gen_string(input int max_units);
    int n;
    logic [15:0] u;
    queue_unit(MODE_START, 16'($urandom()));
    n = $urandom_range(0, max_units);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: queue_unit(MODE_UNIT, 16'($urandom_range(16'h20, 16'h7e)));
        6, 7: begin
          case ($urandom_range(0, 6))
            0: u = 16'h0022;
            1: u = 16'h005c;
            2: u = 16'h0008;
            3: u = 16'h000c;
            4: u = 16'h000a;
            5: u = 16'h000d;
            default: u = 16'h0009;
          endcase
          queue_unit(MODE_UNIT, u);
        end
        8: queue_unit(MODE_UNIT, 16'($urandom_range(0, 16'h1f)));
        9, 10: queue_unit(MODE_UNIT, 16'($urandom_range(16'h80, 16'h7ff)));
        11, 12: begin
          if ($urandom_range(0, 1) == 0) begin
            u = 16'($urandom_range(16'h800, 16'hd7ff));
          end else begin
            u = 16'($urandom_range(16'he000, 16'hffff));
          end
          queue_unit(MODE_UNIT, u);
        end
        13, 14, 15: begin
          queue_unit(MODE_UNIT, 16'($urandom_range(16'hd800, 16'hdbff)));
          queue_unit(MODE_UNIT, 16'($urandom_range(16'hdc00, 16'hdfff)));
        end
        16: queue_unit(MODE_UNIT, 16'($urandom()));
        17: queue_unit(MODE_UNIT, 16'($urandom_range(16'hdc00, 16'hdfff)));
        18: begin
          queue_unit(MODE_UNIT, 16'($urandom_range(16'hd800, 16'hdbff)));
          queue_unit(MODE_UNIT, 16'($urandom_range(16'h20, 16'h7e)));
        end
        default: queue_unit(MODE_RSVD, 16'($urandom()));
      endcase
    end
    case ($urandom_range(0, 11))
      0: ;
      1: begin
        queue_unit(MODE_UNIT, 16'($urandom_range(16'hd800, 16'hdbff)));
        queue_unit(MODE_END, 16'($urandom()));
      end
      default: queue_unit(MODE_END, 16'($urandom()));
    endcase
  endtask

  task automatic run_random(input int target, input int max_units);
    int unsigned base;
    base = n_queued;
    while (n_queued - base < target) begin
      gen_string(max_units);
      // now and then a unit after the string, whether or not it was closed
      if ($urandom_range(0, 7) == 0) begin
        queue_unit(MODE_UNIT, 16'($urandom_range(0, 16'h7ff)));
      end
    end
    drain();
  endtask

  // input side: one item in flight, random idle bursts between transfers
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_acc_cnt != in_seen_cnt) begin
        in_seen_cnt = in_acc_cnt;
        in_busy = 1'b0;
      end
      if (!in_busy) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (!calm && unit_q.size() != 0 && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(1, 18) - 1;
          in_valid <= 1'b0;
        end else if (unit_q.size() != 0) begin
          in_mode <= unit_q[0].mode;
          in_cu <= unit_q[0].cu;
          void'(unit_q.pop_front());
          in_valid <= 1'b1;
          in_busy = 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_gap = $urandom_range(1, 18) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        escape_item(in_ch.mode, in_ch.code_unit);
        in_acc_cnt++;
      end
      if (out_ch.valid && out_ch.ready) begin
        n_bytes++;
        if (json_q.size() == 0) begin
          report($sformatf("unexpected byte %02h last %0b err %0d",
                           out_ch.out_byte, out_ch.run_last, out_ch.error_code));
        end else if (json_q[0].ob != out_ch.out_byte || json_q[0].last != out_ch.run_last ||
                     json_q[0].err != out_ch.error_code) begin
          report($sformatf("expected byte %02h last %0b err %0d, got byte %02h last %0b err %0d",
                           json_q[0].ob, json_q[0].last, json_q[0].err,
                           out_ch.out_byte, out_ch.run_last, out_ch.error_code));
          void'(json_q.pop_front());
        end else begin
          void'(json_q.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      wd_count <= 0;
    end else if (wd_count >= WD_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WD_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      wd_count <= wd_count + 1;
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    write_limit(19'd262144);
    // escapes, utf-8 length boundaries and surrogate pair extremes
    queue_unit(MODE_START, 16'hffff);
    queue_unit(MODE_UNIT, 16'h0000);
    queue_unit(MODE_UNIT, 16'h001f);
    queue_unit(MODE_UNIT, 16'h0008);
    queue_unit(MODE_UNIT, 16'h0009);
    queue_unit(MODE_UNIT, 16'h000a);
    queue_unit(MODE_UNIT, 16'h000c);
    queue_unit(MODE_UNIT, 16'h000d);
    queue_unit(MODE_UNIT, 16'h0022);
    queue_unit(MODE_UNIT, 16'h005c);
    queue_unit(MODE_UNIT, 16'h0080);
    queue_unit(MODE_UNIT, 16'h07ff);
    queue_unit(MODE_UNIT, 16'h0800);
    queue_unit(MODE_UNIT, 16'hffff);
    queue_unit(MODE_UNIT, 16'hd800);
    queue_unit(MODE_UNIT, 16'hdc00);
    queue_unit(MODE_UNIT, 16'hdbff);
    queue_unit(MODE_UNIT, 16'hdfff);
    queue_unit(MODE_END, 16'h0000);
    drain();

    // zero limit: pairing errors come before the length check
    write_limit(19'd0);
    queue_unit(MODE_START, 16'h0000);
    queue_unit(MODE_UNIT, 16'hd800);
    queue_unit(MODE_UNIT, 16'h0041);
    queue_unit(MODE_START, 16'h0000);
    queue_unit(MODE_UNIT, 16'hdbff);
    queue_unit(MODE_END, 16'h0000);
    queue_unit(MODE_START, 16'h0000);
    queue_unit(MODE_UNIT, 16'hdc00);
    queue_unit(MODE_END, 16'h0000);
    queue_unit(MODE_START, 16'h0000);
    queue_unit(MODE_UNIT, 16'h0041);
    drain();

    write_limit(19'd7);
    run_random(45, 8);
    write_limit(19'd1);
    run_random(20, 4);
    write_limit(19'd30);
    run_random(50, 12);
    write_limit(19'd262144);
    calm = 1'b1;
    run_random(95, 12);

    if (json_q.size() != 0) begin
      report($sformatf("%0d expected bytes never arrived", json_q.size()));
    end
    $display("drove %0d input items, checked %0d output bytes", n_queued, n_bytes);
    $display("covered %0d limit writes from 0 up to 262144, with and without stalls", n_limits);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
